FILE: hdl/gsp_pkg.sv
package gsp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_HEX1,
		PH_HEX2,
		PH_TAIL
	} phase_t;

	localparam logic [2:0] RC_OK     = 3'd0;
	localparam logic [2:0] RC_HEX    = 3'd1;
	localparam logic [2:0] RC_SUM    = 3'd2;
	localparam logic [2:0] RC_COUNT  = 3'd3;
	localparam logic [2:0] RC_STATUS = 3'd4;
	localparam logic [2:0] RC_ID     = 3'd5;
	localparam logic [2:0] RC_LONG   = 3'd6;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_FIVE   = 8'h35;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;

	localparam logic [4:0] FLD_UTC   = 5'd2;
	localparam logic [4:0] FLD_LAT   = 5'd3;
	localparam logic [4:0] FLD_LON   = 5'd4;
	localparam logic [4:0] FLD_HDG   = 5'd6;
	localparam logic [4:0] FLD_SPD   = 5'd11;
	localparam logic [4:0] FLD_GX    = 5'd12;
	localparam logic [4:0] FLD_GY    = 5'd13;
	localparam logic [4:0] FLD_ST0   = 5'd16;
	localparam logic [4:0] FLD_ST1   = 5'd17;
	localparam logic [4:0] FLD_SAT   = 5'd18;
	localparam logic [4:0] NUM_COMMAS = 5'd23;
	localparam logic [4:0] COMMA_MAX  = 5'd31;

	localparam logic [4:0]  TZ_RESET = 5'd8;
	localparam logic [39:0] ID_RESET = 40'd306290704973;

	localparam int MAG_W  = 60;
	localparam int FRAC_W = 30;
	localparam logic [63:0] MAG_CAP = 64'd1000000000000000000;

	localparam logic [0:0] CFG_TZ = 1'b0;
	localparam logic [0:0] CFG_ID = 1'b1;

	typedef struct packed {
		logic [MAG_W-1:0]  mag;
		logic              neg;
		logic [7:0]        hh;
		logic [3:0]        d3;
		logic [3:0]        d2;
		logic [3:0]        d1;
		logic [3:0]        d0;
		logic [FRAC_W-1:0] frac;
		logic              first;
	} num_t;

	typedef struct packed {
		logic              utc_neg;
		logic              utc_cap;
		logic [7:0]        utc_hh;
		logic [6:0]        utc_mm;
		logic [6:0]        utc_ss;
		logic [FRAC_W-1:0] utc_frac;
		logic [36:0]       lat;
		logic [37:0]       lon;
		logic [39:0]       hdg;
		logic [40:0]       spd;
		logic [57:0]       gx;
		logic [57:0]       gy;
		logic [6:0]        sat;
		logic [7:0]        st0;
		logic [7:0]        st1;
	} fields_t;

	function automatic logic [63:0] pow10(input logic [3:0] n);
		logic [63:0] r;
		case (n)
			4'd0: r = 64'd1;
			4'd1: r = 64'd10;
			4'd2: r = 64'd100;
			4'd3: r = 64'd1000;
			4'd4: r = 64'd10000;
			4'd5: r = 64'd100000;
			4'd6: r = 64'd1000000;
			4'd7: r = 64'd10000000;
			4'd8: r = 64'd100000000;
			4'd9: r = 64'd1000000000;
			default: r = 64'd1;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] r;
		if (b >= CH_ZERO && b <= CH_NINE)
			r = {1'b1, 4'(b - CH_ZERO)};
		else if (b >= CH_UA && b <= CH_UF)
			r = {1'b1, 4'(b - CH_UA + 8'd10)};
		else
			r = 5'd0;
		return r;
	endfunction

	function automatic logic [63:0] clamp_u(input logic [MAG_W-1:0] m, input logic n,
			input logic [63:0] lim);
		logic [63:0] r;
		if (n)
			r = 64'd0;
		else if (64'(m) > lim)
			r = lim;
		else
			r = 64'(m);
		return r;
	endfunction

	function automatic logic [63:0] clamp_s(input logic [MAG_W-1:0] m, input logic n,
			input logic [63:0] lim);
		logic [63:0] r;
		r = (64'(m) > lim) ? lim : 64'(m);
		if (n)
			r = 64'd0 - r;
		return r;
	endfunction

endpackage

FILE: hdl/gsp_number.sv
module gsp_number #(
	parameter int FRAC_DIGITS = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clr,
	input  logic           tick,
	input  logic           feed,
	input  logic [7:0]     rx,
	output gsp_pkg::num_t  st
);
	import gsp_pkg::*;

	localparam logic [63:0] SCALE = pow10(4'(FRAC_DIGITS));
	localparam logic [3:0]  FD    = 4'(FRAC_DIGITS);

	num_t       st_q;
	logic [1:0] mode_q;
	logic [3:0] seen_q;

	logic        is_digit;
	logic [3:0]  dig;
	logic [64:0] int_sum;
	logic [64:0] frac_sum;
	logic [63:0] frac_add;
	logic [3:0]  frac_pos;
	logic [11:0] hh_next;

	always_comb begin
		is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
		dig      = 4'(rx - CH_ZERO);
		int_sum  = 65'(st_q.mag) * 65'd10 + 65'(dig) * 65'(SCALE);
		frac_pos = FD - seen_q - 4'd1;
		frac_add = 64'(dig) * pow10(frac_pos);
		frac_sum = 65'(st_q.mag) + 65'(frac_add);
		hh_next  = 12'(st_q.hh) * 12'd10 + 12'(st_q.d3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			st_q.first <= 1'b1;
			mode_q <= 2'd0;
			seen_q <= 4'd0;
		end else if (clr) begin
			st_q   <= '0;
			st_q.first <= 1'b1;
			mode_q <= 2'd0;
			seen_q <= 4'd0;
		end else begin
			if (tick)
				st_q.first <= 1'b0;
			if (feed && mode_q != 2'd3) begin
				if (is_digit) begin
					if (mode_q < 2'd2) begin
						mode_q  <= 2'd1;
						st_q.mag <= (int_sum > 65'(MAG_CAP)) ? MAG_W'(MAG_CAP)
							: MAG_W'(int_sum);
						st_q.hh <= (hh_next > 12'd255) ? 8'd255 : 8'(hh_next);
						st_q.d3 <= st_q.d2;
						st_q.d2 <= st_q.d1;
						st_q.d1 <= st_q.d0;
						st_q.d0 <= dig;
					end else if (seen_q < FD) begin
						seen_q   <= seen_q + 4'd1;
						st_q.mag <= (frac_sum > 65'(MAG_CAP)) ? MAG_W'(MAG_CAP)
							: MAG_W'(frac_sum);
						st_q.frac <= st_q.frac + FRAC_W'(frac_add);
					end
				end else if ((rx == CH_PLUS || rx == CH_MINUS) && mode_q == 2'd0) begin
					st_q.neg <= (rx == CH_MINUS);
					mode_q   <= 2'd1;
				end else if (rx == CH_DOT && mode_q < 2'd2) begin
					mode_q <= 2'd2;
				end else begin
					mode_q <= 2'd3;
				end
			end
		end
	end

	assign st = st_q;

endmodule

FILE: hdl/gsp_result.sv
module gsp_result #(
	parameter int FRAC_DIGITS = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [2:0]         code,
	input  gsp_pkg::fields_t   fv,
	input  logic [4:0]         tz,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [2:0]         result_code,
	output logic [46:0]        utc_seconds,
	output logic [36:0]        latitude,
	output logic [37:0]        longitude,
	output logic signed [39:0] heading,
	output logic signed [40:0] speed,
	output logic signed [57:0] grid_x,
	output logic signed [57:0] grid_y,
	output logic [2:0]         status_primary,
	output logic [2:0]         status_secondary,
	output logic [6:0]         satellite_count,
	output logic [2:0]         fix_quality
);
	import gsp_pkg::*;

	localparam logic [63:0] SCALE   = pow10(4'(FRAC_DIGITS));
	localparam logic [63:0] UTC_MAX = 64'd111600 * SCALE - 64'd1;

	logic [20:0] t_sec;
	logic [63:0] utc_full;
	logic [46:0] utc_val;
	logic [2:0]  a;
	logic [2:0]  b;
	logic [2:0]  fq;
	logic        ok;

	logic        valid_q;
	logic [2:0]  code_q;
	logic [46:0] utc_q;
	logic [36:0] lat_q;
	logic [37:0] lon_q;
	logic [39:0] hdg_q;
	logic [40:0] spd_q;
	logic [57:0] gx_q;
	logic [57:0] gy_q;
	logic [2:0]  st0_q;
	logic [2:0]  st1_q;
	logic [6:0]  sat_q;
	logic [2:0]  fq_q;

	always_comb begin
		t_sec = (21'(fv.utc_hh) + 21'(tz)) * 21'd3600 + 21'(fv.utc_mm) * 21'd60
			+ 21'(fv.utc_ss);
		utc_full = 64'(t_sec) * SCALE + 64'(fv.utc_frac);
		if (fv.utc_neg)
			utc_val = 47'd0;
		else if (fv.utc_cap || utc_full > UTC_MAX)
			utc_val = 47'(UTC_MAX);
		else
			utc_val = 47'(utc_full);
		a = 3'(fv.st0 - CH_ZERO);
		b = 3'(fv.st1 - CH_ZERO);
		if (a == 3'd4 && b == 3'd4)
			fq = 3'd4;
		else if ((a == 3'd4 && b == 3'd5) || (a == 3'd5 && b == 3'd4))
			fq = 3'd5;
		else
			fq = (a < b) ? a : b;
		ok = (code == RC_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= code;
			utc_q  <= ok ? utc_val : '0;
			lat_q  <= ok ? fv.lat : '0;
			lon_q  <= ok ? fv.lon : '0;
			hdg_q  <= ok ? fv.hdg : '0;
			spd_q  <= ok ? fv.spd : '0;
			gx_q   <= ok ? fv.gx : '0;
			gy_q   <= ok ? fv.gy : '0;
			st0_q  <= ok ? a : '0;
			st1_q  <= ok ? b : '0;
			sat_q  <= ok ? fv.sat : '0;
			fq_q   <= ok ? fq : '0;
		end
	end

	assign out_valid        = valid_q;
	assign result_code      = code_q;
	assign utc_seconds      = utc_q;
	assign latitude         = lat_q;
	assign longitude        = lon_q;
	assign heading          = hdg_q;
	assign speed            = spd_q;
	assign grid_x           = gx_q;
	assign grid_y           = gy_q;
	assign status_primary   = st0_q;
	assign status_secondary = st1_q;
	assign satellite_count  = sat_q;
	assign fix_quality      = fq_q;

endmodule

FILE: hdl/gnss_sentence_parser_unit.sv
// Parses NMEA-style sentences one byte per clock: a word is registered on entry, and from
// that input register updates checksum, counters and the decimal accumulator; on the closing
// newline the result goes to the output register. With no stall on the result side the
// block takes one word every cycle; a stall holds the word in the input register. Only words
// that end a sentence (newline, or a byte that would exceed MAX_LEN) produce a result; a
// '$' restarts parsing at once without a result.
module gnss_sentence_parser_unit #(
	parameter int FRAC_DIGITS = 9,
	parameter int MAX_LEN     = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [39:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         result_code,
	output logic [46:0]        utc_seconds,
	output logic [36:0]        latitude,
	output logic [37:0]        longitude,
	output logic signed [39:0] heading,
	output logic signed [40:0] speed,
	output logic signed [57:0] grid_x,
	output logic signed [57:0] grid_y,
	output logic [2:0]         status_primary,
	output logic [2:0]         status_secondary,
	output logic [6:0]         satellite_count,
	output logic [2:0]         fix_quality
);
	import gsp_pkg::*;

	localparam int BP_W = $clog2(MAX_LEN);
	localparam logic [63:0] SCALE    = pow10(4'(FRAC_DIGITS));
	localparam logic [63:0] LAT_LIM  = 64'd90 * SCALE;
	localparam logic [63:0] LON_LIM  = 64'd180 * SCALE;
	localparam logic [63:0] HDG_LIM  = 64'd360 * SCALE;
	localparam logic [63:0] SPD_LIM  = 64'd1000 * SCALE;
	localparam logic [63:0] GRID_LIM = 64'd100000000 * SCALE;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       proc;

	phase_t          phase_q, phase_d;
	logic [7:0]      xor_q;
	logic [7:0]      sum_q;
	logic [BP_W-1:0] pos_q;
	logic [BP_W-1:0] pos_inc;
	logic [4:0]      comma_q;
	logic [39:0]     id_q;
	logic            id_ok_q;
	logic            err_q;
	logic [4:0]      tz_q;
	logic [39:0]     sid_q;
	fields_t         fv_q;
	num_t            num;

	logic       start, fin, do_close, do_xor, do_id, do_comma, do_hex1, do_hex2;
	logic       tick, feed_num, st_store0, st_store1, inc_pos, over, is_nl;
	logic [2:0] code;
	logic [4:0] hv;
	logic       num_cap;
	logic [6:0] mm_v, ss_v;

	assign in_stall = valid_s1 && out_valid && out_stall;
	assign proc     = valid_s1 && !(out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q  <= TZ_RESET;
			sid_q <= ID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TZ: tz_q <= cfg_data[4:0];
				CFG_ID: sid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_inc = pos_q + BP_W'(1);
		over    = ({1'b0, pos_q} + (BP_W+1)'(2)) > (BP_W+1)'(MAX_LEN);
		is_nl   = (byte_s1 == CH_NL);
		hv      = hex_val(byte_s1);
	end

	always_comb begin
		phase_d = phase_q;
		if (proc) begin
			if (start)
				phase_d = PH_BODY;
			else if (fin)
				phase_d = PH_IDLE;
			else begin
				case (phase_q)
					PH_BODY: if (byte_s1 == CH_STAR) phase_d = PH_HEX1;
					PH_HEX1: phase_d = PH_HEX2;
					PH_HEX2: phase_d = PH_TAIL;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		start = 1'b0; fin = 1'b0; do_close = 1'b0; do_xor = 1'b0; do_id = 1'b0;
		do_comma = 1'b0; do_hex1 = 1'b0; do_hex2 = 1'b0; tick = 1'b0; feed_num = 1'b0;
		st_store0 = 1'b0; st_store1 = 1'b0; inc_pos = 1'b0; code = RC_OK;
		if (proc) begin
			if (byte_s1 == CH_DOLLAR)
				start = 1'b1;
			else if (phase_q != PH_IDLE) begin
				if (over) begin
					fin  = 1'b1;
					code = RC_LONG;
				end else begin
					inc_pos = 1'b1;
					case (phase_q)
						PH_BODY: begin
							if (is_nl) begin
								fin  = 1'b1;
								code = RC_HEX;
							end else if (byte_s1 == CH_STAR)
								do_close = 1'b1;
							else begin
								do_xor = 1'b1;
								if (pos_inc <= BP_W'(5))
									do_id = 1'b1;
								else if (byte_s1 == CH_COMMA) begin
									do_close = 1'b1;
									do_comma = 1'b1;
								end else begin
									tick = 1'b1;
									if (comma_q == FLD_ST0)
										st_store0 = num.first;
									else if (comma_q == FLD_ST1)
										st_store1 = num.first;
									else if (comma_q inside {FLD_UTC, FLD_HDG, FLD_SPD,
											FLD_GX, FLD_GY, FLD_SAT})
										feed_num = 1'b1;
									else if (comma_q inside {FLD_LAT, FLD_LON})
										feed_num = !num.first;
								end
							end
						end
						PH_HEX1: begin
							if (is_nl) begin
								fin  = 1'b1;
								code = RC_HEX;
							end else
								do_hex1 = 1'b1;
						end
						PH_HEX2: begin
							if (is_nl) begin
								fin  = 1'b1;
								code = RC_HEX;
							end else
								do_hex2 = 1'b1;
						end
						PH_TAIL: begin
							if (is_nl) begin
								fin = 1'b1;
								if (err_q)
									code = RC_HEX;
								else if (xor_q != sum_q)
									code = RC_SUM;
								else if (!id_ok_q)
									code = RC_ID;
								else if (comma_q != NUM_COMMAS)
									code = RC_COUNT;
								else if (!(fv_q.st0 inside {[CH_ZERO:CH_FIVE]}) ||
										!(fv_q.st1 inside {[CH_ZERO:CH_FIVE]}))
									code = RC_STATUS;
								else
									code = RC_OK;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= PH_IDLE;
		else
			phase_q <= phase_d;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xor_q   <= 8'd0;
			sum_q   <= 8'd0;
			pos_q   <= '0;
			comma_q <= 5'd0;
			id_q    <= 40'd0;
			id_ok_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			if (inc_pos)
				pos_q <= pos_inc;
			if (do_xor)
				xor_q <= xor_q ^ byte_s1;
			if (do_id)
				id_q <= {id_q[31:0], byte_s1};
			if (do_comma && comma_q != COMMA_MAX)
				comma_q <= comma_q + 5'd1;
			if (do_close && !do_comma)
				id_ok_q <= (pos_q >= BP_W'(5)) && (id_q == sid_q);
			if (do_hex1) begin
				sum_q <= {hv[3:0], 4'd0};
				if (!hv[4])
					err_q <= 1'b1;
			end
			if (do_hex2) begin
				sum_q[3:0] <= hv[3:0];
				if (!hv[4])
					err_q <= 1'b1;
			end
		end
	end

	always_comb begin
		num_cap = (64'(num.mag) == MAG_CAP);
		mm_v    = 7'(num.d3) * 7'd10 + 7'(num.d2);
		ss_v    = 7'(num.d1) * 7'd10 + 7'(num.d0);
	end

	always_ff @(posedge clk) begin
		if (start)
			fv_q <= '0;
		else begin
			if (st_store0)
				fv_q.st0 <= byte_s1;
			if (st_store1)
				fv_q.st1 <= byte_s1;
			if (do_close) begin
				case (comma_q)
					FLD_UTC: begin
						fv_q.utc_neg  <= num.neg;
						fv_q.utc_cap  <= num_cap;
						fv_q.utc_hh   <= num.hh;
						fv_q.utc_mm   <= mm_v;
						fv_q.utc_ss   <= ss_v;
						fv_q.utc_frac <= num.frac;
					end
					FLD_LAT: fv_q.lat <= 37'(clamp_u(num.mag, num.neg, LAT_LIM));
					FLD_LON: fv_q.lon <= 38'(clamp_u(num.mag, num.neg, LON_LIM));
					FLD_HDG: fv_q.hdg <= 40'(clamp_s(num.mag, num.neg, HDG_LIM));
					FLD_SPD: fv_q.spd <= 41'(clamp_s(num.mag, num.neg, SPD_LIM));
					FLD_GX:  fv_q.gx  <= 58'(clamp_s(num.mag, num.neg, GRID_LIM));
					FLD_GY:  fv_q.gy  <= 58'(clamp_s(num.mag, num.neg, GRID_LIM));
					FLD_SAT: begin
						if (num.neg)
							fv_q.sat <= 7'd0;
						else if (num_cap || num.hh != 8'd0 || num.d3 != 4'd0 ||
								num.d2 != 4'd0)
							fv_q.sat <= 7'd99;
						else
							fv_q.sat <= ss_v;
					end
					default: ;
				endcase
			end
		end
	end

	gsp_number #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_number (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (start || do_close),
		.tick   (tick),
		.feed   (feed_num),
		.rx     (byte_s1),
		.st     (num)
	);

	gsp_result #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_result (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (fin),
		.code             (code),
		.fv               (fv_q),
		.tz               (tz_q),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.result_code      (result_code),
		.utc_seconds      (utc_seconds),
		.latitude         (latitude),
		.longitude        (longitude),
		.heading          (heading),
		.speed            (speed),
		.grid_x           (grid_x),
		.grid_y           (grid_y),
		.status_primary   (status_primary),
		.status_secondary (status_secondary),
		.satellite_count  (satellite_count),
		.fix_quality      (fix_quality)
	);

	a_result_from_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result without a word in the input register");

	a_finish_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (phase_q == PH_IDLE))
		else $error("parser not idle after a result");

	a_ok_needs_commas: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && code == RC_OK) |-> (comma_q == NUM_COMMAS && id_ok_q && !err_q))
		else $error("ok result on a malformed sentence");

endmodule

FILE: test/tb_gnss_sentence_parser_unit.sv
`timescale 1ns / 100ps

module tb_gnss_sentence_parser_unit;
	import gsp_pkg::*;

	localparam int          MAX_LEN = 512;
	localparam logic [63:0] SCL     = 64'd1000000000;
	localparam logic [63:0] CAP     = 64'd1000000000000000000;

	typedef struct packed {
		logic [2:0]  code;
		logic [46:0] utc;
		logic [36:0] lat;
		logic [37:0] lon;
		logic [39:0] hdg;
		logic [40:0] spd;
		logic [57:0] gx;
		logic [57:0] gy;
		logic [2:0]  st0;
		logic [2:0]  st1;
		logic [6:0]  sat;
		logic [2:0]  fix;
	} fix_report_t;

	typedef enum int {
		SM_OK, SM_BADSUM, SM_LOWHEX, SM_NONHEX, SM_NL_BODY, SM_NL_STAR, SM_NL_HEX1,
		SM_CR_TAIL, SM_COUNT, SM_BADID, SM_SHORTID, SM_RESTART, SM_STRAY, SM_MANYCOMMA
	} sent_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = CFG_TZ;
	logic [39:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_code;
	logic [46:0] utc_seconds;
	logic [36:0] latitude;
	logic [37:0] longitude;
	logic signed [39:0] heading;
	logic signed [40:0] speed;
	logic signed [57:0] grid_x;
	logic signed [57:0] grid_y;
	logic [2:0]  status_primary;
	logic [2:0]  status_secondary;
	logic [6:0]  satellite_count;
	logic [2:0]  fix_quality;

	gnss_sentence_parser_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// parser copy
	logic [4:0]  tz;
	logic [39:0] sid;
	phase_t      ph;
	logic [7:0]  run_xor, got_sum;
	int unsigned pos, ncomma, cif, nfrac, nmode;
	logic [39:0] idsh;
	logic [63:0] acc;
	bit          neg, id_match, hex_bad;
	logic [63:0] fv [8];
	logic [7:0]  stc [2];

	logic [7:0]  word_q [$];
	fix_report_t report_q [$];
	string       fx [36];
	int          fails = 0;
	int          bytes_taken = 0;

	function automatic logic [63:0] pow_ten(int n);
		logic [63:0] r;
		r = 64'd1;
		repeat (n) r = r * 10;
		return r;
	endfunction

	function automatic void clear_num();
		acc = '0; nfrac = 0; neg = 0; nmode = 0; cif = 0;
	endfunction

	function automatic void start_sentence();
		ph = PH_BODY; run_xor = '0; got_sum = '0; pos = 0; ncomma = 0; idsh = '0;
		hex_bad = 0; id_match = 0;
		foreach (fv[i]) fv[i] = '0;
		stc[0] = '0; stc[1] = '0;
		clear_num();
	endfunction

	function automatic int slot_of(int unsigned f);
		case (f)
			FLD_UTC: return 0;
			FLD_LAT: return 1;
			FLD_LON: return 2;
			FLD_HDG: return 3;
			FLD_SPD: return 4;
			FLD_GX:  return 5;
			FLD_GY:  return 6;
			FLD_SAT: return 7;
			default: return -1;
		endcase
	endfunction

	function automatic void close_field(int unsigned f);
		int s;
		s = slot_of(f);
		if (s >= 0)
			fv[s] = acc | {neg, 63'd0};
		clear_num();
	endfunction

	function automatic void feed_char(int unsigned f, logic [7:0] b);
		int unsigned c;
		logic [63:0] d;
		c = cif;
		if (cif < 31)
			cif++;
		if (f == FLD_ST0 || f == FLD_ST1) begin
			if (c == 0)
				stc[f - FLD_ST0] = b;
			return;
		end
		if (slot_of(f) < 0 || ((f == FLD_LAT || f == FLD_LON) && c == 0) || nmode == 3)
			return;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			d = 64'(b - CH_ZERO);
			if (nmode < 2) begin
				nmode = 1;
				acc = acc * 10 + d * SCL;
			end else if (nfrac < 9) begin
				nfrac++;
				acc = acc + d * pow_ten(9 - nfrac);
			end
			if (acc > CAP)
				acc = CAP;
		end else if ((b == CH_PLUS || b == CH_MINUS) && nmode == 0) begin
			neg = (b == CH_MINUS);
			nmode = 1;
		end else if (b == CH_DOT && nmode < 2) begin
			nmode = 2;
		end else begin
			nmode = 3;
		end
	endfunction

	function automatic logic [63:0] sat_u(logic [63:0] v, logic [63:0] lim);
		if (v[63])
			return '0;
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [63:0] sat_s(logic [63:0] v, logic [63:0] lim);
		logic [63:0] m;
		m = {1'b0, v[62:0]};
		if (m > lim)
			m = lim;
		if (v[63])
			m = 64'd0 - m;
		return m;
	endfunction

	function automatic fix_report_t close_sentence(logic [2:0] code);
		fix_report_t r;
		logic [63:0] v, ip, fp, t, u, n;
		logic [2:0]  a, b;
		r = '0;
		ph = PH_IDLE;
		r.code = code;
		if (code != RC_OK)
			return r;
		v = fv[0];
		u = '0;
		if (!v[63]) begin
			ip = v / SCL;
			fp = v % SCL;
			t = (ip / 10000 + 64'(tz)) * 3600 + ((ip / 100) % 100) * 60 + ip % 100;
			u = t * SCL + fp;
			if (u > 111600 * SCL - 1)
				u = 111600 * SCL - 1;
		end
		r.utc = u[46:0];
		r.lat = 37'(sat_u(fv[1], 90 * SCL));
		r.lon = 38'(sat_u(fv[2], 180 * SCL));
		r.hdg = 40'(sat_s(fv[3], 360 * SCL));
		r.spd = 41'(sat_s(fv[4], 1000 * SCL));
		r.gx = 58'(sat_s(fv[5], 100000000 * SCL));
		r.gy = 58'(sat_s(fv[6], 100000000 * SCL));
		a = 3'(stc[0] - CH_ZERO);
		b = 3'(stc[1] - CH_ZERO);
		n = sat_u(fv[7], CAP) / SCL;
		r.st0 = a;
		r.st1 = b;
		r.sat = (n > 99) ? 7'd99 : 7'(n);
		if (a == 4 && b == 4)
			r.fix = 3'd4;
		else if ((a == 4 && b == 5) || (a == 5 && b == 4))
			r.fix = 3'd5;
		else
			r.fix = (a < b) ? a : b;
		return r;
	endfunction

	function automatic int hex_digit(logic [7:0] b);
		if (b >= CH_ZERO && b <= CH_NINE)
			return int'(b - CH_ZERO);
		if (b >= CH_UA && b <= CH_UF)
			return int'(b - CH_UA) + 10;
		return -1;
	endfunction

	function automatic bit parse_byte(logic [7:0] b, output fix_report_t r);
		int unsigned j;
		int h;
		r = '0;
		if (b == CH_DOLLAR) begin
			start_sentence();
			return 0;
		end
		if (ph == PH_IDLE)
			return 0;
		if (pos + 2 > MAX_LEN) begin
			r = close_sentence(RC_LONG);
			return 1;
		end
		pos++;
		j = pos;
		case (ph)
			PH_BODY: begin
				if (b == CH_NL) begin
					r = close_sentence(RC_HEX);
					return 1;
				end
				if (b == CH_STAR) begin
					close_field(ncomma);
					id_match = (j - 1 >= 5) && (idsh == sid);
					ph = PH_HEX1;
					return 0;
				end
				run_xor ^= b;
				if (j <= 5)
					idsh = {idsh[31:0], b};
				else if (b == CH_COMMA) begin
					close_field(ncomma);
					if (ncomma < COMMA_MAX)
						ncomma++;
				end else
					feed_char(ncomma, b);
			end
			PH_HEX1, PH_HEX2: begin
				if (b == CH_NL) begin
					r = close_sentence(RC_HEX);
					return 1;
				end
				h = hex_digit(b);
				if (h < 0) begin
					hex_bad = 1;
					h = 0;
				end
				if (ph == PH_HEX1) begin
					got_sum = {4'(h), 4'd0};
					ph = PH_HEX2;
				end else begin
					got_sum[3:0] = 4'(h);
					ph = PH_TAIL;
				end
			end
			default: begin
				if (b != CH_NL)
					return 0;
				if (hex_bad)
					r = close_sentence(RC_HEX);
				else if (run_xor != got_sum)
					r = close_sentence(RC_SUM);
				else if (!id_match)
					r = close_sentence(RC_ID);
				else if (ncomma != NUM_COMMAS)
					r = close_sentence(RC_COUNT);
				else if (stc[0] < CH_ZERO || stc[0] > CH_FIVE ||
						stc[1] < CH_ZERO || stc[1] > CH_FIVE)
					r = close_sentence(RC_STATUS);
				else
					r = close_sentence(RC_OK);
				return 1;
			end
		endcase
		return 0;
	endfunction

	// sentence text
	function automatic string rand_digits(int n);
		string s;
		s = "";
		repeat (n) s = $sformatf("%s%0d", s, $urandom_range(9));
		return s;
	endfunction

	function automatic string rand_number(int maxi);
		string s, jk;
		int r, k;
		s = "";
		jk = ".+-xA";
		r = $urandom_range(9);
		if (r == 0)
			return s;
		if (r == 1)
			s = "-";
		else if (r == 2)
			s = "+";
		if ($urandom_range(7) == 0)
			maxi = 22;
		s = {s, rand_digits($urandom_range(maxi))};
		if ($urandom_range(2) != 0)
			s = {s, ".", rand_digits($urandom_range(12))};
		if ($urandom_range(11) == 0) begin
			k = $urandom_range(4);
			s = {s, jk.substr(k, k), rand_digits(2)};
		end
		return s;
	endfunction

	function automatic string rand_field(int f);
		string hs;
		int r;
		hs = "NS-+";
		r = $urandom_range(3);
		case (f)
			FLD_UTC: return ($urandom_range(4) != 0) ? $sformatf("%02d%02d%02d.%0d",
				$urandom_range(23), $urandom_range(59), $urandom_range(59),
				$urandom_range(999)) : rand_number(7);
			FLD_LAT, FLD_LON: return ($urandom_range(7) == 0) ? "" :
				{hs.substr(r, r), rand_number(3)};
			FLD_HDG: return rand_number(3);
			FLD_SPD: return rand_number(4);
			FLD_GX, FLD_GY: return rand_number(9);
			FLD_ST0, FLD_ST1: begin
				r = $urandom_range(11);
				if (r < 9)
					return $sformatf("%0d", $urandom_range(5));
				if (r == 9)
					return "";
				if (r == 10)
					return $sformatf("%0d", $urandom_range(6, 9));
				return "A";
			end
			FLD_SAT: return ($urandom_range(3) != 0) ?
				$sformatf("%0d", $urandom_range(150)) : rand_number(3);
			default: return ($urandom_range(3) == 0) ? {"A", rand_digits(2)} : "";
		endcase
	endfunction

	function automatic void clear_fx();
		foreach (fx[i]) fx[i] = "?";
	endfunction

	function automatic void emit_sentence(sent_mode_e m);
		logic [7:0] body [$];
		logic [7:0] cs, b;
		string s, tail;
		int nc, k, p;
		nc = (m == SM_COUNT) ? ($urandom_range(1) ? 24 : 22) :
			(m == SM_MANYCOMMA) ? 35 : 23;
		for (k = 0; k < 5; k++)
			body.push_back(sid[39 - 8 * k -: 8]);
		if (m == SM_BADID) begin
			k = $urandom_range(4);
			body[k] ^= 8'(1 << $urandom_range(7));
			if (body[k] == CH_DOLLAR || body[k] == CH_STAR || body[k] == CH_NL)
				body[k] = CH_UA;
		end
		if (m == SM_SHORTID) begin
			k = $urandom_range(1, 4);
			while (body.size() > k)
				void'(body.pop_back());
		end else begin
			for (k = 1; k <= nc; k++) begin
				body.push_back(CH_COMMA);
				s = (fx[k] != "?") ? fx[k] : rand_field(k);
				foreach (s[i]) body.push_back(s[i]);
			end
		end
		if (m == SM_STRAY) begin
			do b = 8'($urandom_range(1, 255));
			while (b == CH_DOLLAR || b == CH_STAR || b == CH_NL);
			body.insert($urandom_range(5, body.size()), b);
		end
		cs = '0;
		foreach (body[i]) cs ^= body[i];
		case (m)
			SM_BADSUM:  tail = $sformatf("*%02X\n", cs ^ 8'($urandom_range(1, 255)));
			SM_LOWHEX:  tail = $sformatf("*f%1X\n", cs[3:0]);
			SM_NONHEX:  tail = $sformatf("*%1XG\n", cs[7:4]);
			SM_NL_BODY: tail = "\n";
			SM_NL_STAR: tail = "*\n";
			SM_NL_HEX1: tail = $sformatf("*%1X\n", cs[7:4]);
			SM_CR_TAIL: tail = $sformatf("*%02X\r\n", cs);
			default:    tail = $sformatf("*%02X\n", cs);
		endcase
		if (m == SM_RESTART) begin
			word_q.push_back(CH_DOLLAR);
			p = $urandom_range(body.size());
			for (k = 0; k < p; k++)
				word_q.push_back(body[k]);
		end
		word_q.push_back(CH_DOLLAR);
		foreach (body[i]) word_q.push_back(body[i]);
		foreach (tail[i]) word_q.push_back(tail[i]);
	endfunction

	function automatic void emit_random();
		logic [7:0] b;
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 4)) begin
				do b = 8'($urandom_range(255));
				while (b == CH_DOLLAR);
				word_q.push_back(b);
			end
		clear_fx();
		if ($urandom_range(99) < 55)
			emit_sentence(SM_OK);
		else
			emit_sentence(sent_mode_e'($urandom_range(SM_BADSUM, SM_MANYCOMMA)));
	endfunction

	function automatic void emit_padded(int p);
		clear_fx();
		foreach (fx[i]) fx[i] = "";
		fx[1] = "";
		repeat (p) fx[1] = {fx[1], "x"};
		fx[FLD_ST0] = "1";
		fx[FLD_ST1] = "2";
		emit_sentence(SM_OK);
	endfunction

	// sender
	int burst_left = 0, gap_left = 0;

	always @(posedge clk) begin
		fix_report_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				bytes_taken <= bytes_taken + 1;
				if (parse_byte(rx_byte, r))
					report_q.push_back(r);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || word_q.size() == 0) begin
					if (gap_left > 0)
						gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else begin
					rx_byte <= word_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 60);
						gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
					end else
						burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver
	int hold_left = 0, pat_left = 0, pat_mode = 0;
	bit hold_done = 0;
	logic [31:0] pat = '0;

	always @(posedge clk) begin
		bit st;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			st = 0;
			if (!hold_done && bytes_taken >= 2500) begin
				hold_done <= 1;
				hold_left <= 600;
				st = 1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				st = 1;
			end else begin
				if (pat_left == 0) begin
					pat <= $urandom;
					pat_mode <= $urandom_range(3);
					pat_left <= $urandom_range(20, 200);
				end else
					pat_left <= pat_left - 1;
				case (pat_mode)
					1: st = ($urandom_range(3) == 0);
					2: st = pat[pat_left % 32];
					3: st = ($urandom_range(3) != 0);
					default: st = 0;
				endcase
			end
			out_stall <= st;
		end
	end

	// result check
	always @(posedge clk) begin
		fix_report_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{result_code, utc_seconds, latitude, longitude, heading, speed, grid_x,
				grid_y, status_primary, status_secondary, satellite_count, fix_quality};
			if (report_q.size() == 0) begin
				fails <= fails + 1;
				if (fails < 10)
					$display("unexpected result code %0d", result_code);
			end else begin
				want = report_q.pop_front();
				if (got !== want) begin
					fails <= fails + 1;
					if (fails < 10) begin
						$display("mismatch exp: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
							want.code, want.utc, want.lat, want.lon, $signed(want.hdg),
							$signed(want.spd), $signed(want.gx), $signed(want.gy),
							want.st0, want.st1, want.sat, want.fix);
						$display("         got: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
							got.code, got.utc, got.lat, got.lon, $signed(got.hdg),
							$signed(got.spd), $signed(got.gx), $signed(got.gy),
							got.st0, got.st1, got.sat, got.fix);
					end
				end
			end
		end
	end

	task automatic drain();
		do @(posedge clk);
		while (word_q.size() != 0 || in_valid || report_q.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [39:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TZ)
			tz = val[4:0];
		else
			sid = val;
	endtask

	task automatic random_run(int n);
		repeat (n) emit_random();
		drain();
	endtask

	initial begin
		tz = TZ_RESET;
		sid = ID_RESET;
		start_sentence();
		ph = PH_IDLE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		clear_fx();
		fx[FLD_UTC] = "235959.9999999999999"; fx[FLD_LAT] = "N99.5";
		fx[FLD_LON] = "E200.123"; fx[FLD_HDG] = "-400";
		fx[FLD_SPD] = "99999999999999999999999"; fx[FLD_GX] = "-123456789.123456789";
		fx[FLD_GY] = "+100000000.0000000001"; fx[FLD_ST0] = "4"; fx[FLD_ST1] = "4";
		fx[FLD_SAT] = "150";
		emit_sentence(SM_OK);
		clear_fx();
		fx[FLD_UTC] = "-1"; fx[FLD_LAT] = "-5"; fx[FLD_LON] = ""; fx[FLD_HDG] = "1.2.3";
		fx[FLD_SPD] = "12a34"; fx[FLD_SAT] = "-3"; fx[FLD_ST0] = "4"; fx[FLD_ST1] = "5";
		emit_sentence(SM_OK);
		clear_fx();
		fx[FLD_LAT] = "S-5"; fx[FLD_LON] = "+"; fx[FLD_HDG] = "."; fx[FLD_SPD] = "-";
		fx[FLD_GX] = "000000000000000000000000001"; fx[FLD_SAT] = "99.9";
		fx[FLD_ST0] = "5"; fx[FLD_ST1] = "4";
		emit_sentence(SM_OK);
		clear_fx();
		fx[FLD_UTC] = "000000"; fx[FLD_HDG] = "360.0000000001";
		fx[FLD_ST0] = "3"; fx[FLD_ST1] = "1";
		emit_sentence(SM_OK);
		clear_fx();
		fx[FLD_ST0] = "0"; fx[FLD_ST1] = "5";
		emit_sentence(SM_OK);
		clear_fx();
		fx[FLD_ST0] = "";
		emit_sentence(SM_OK);
		clear_fx();
		fx[FLD_ST1] = "6";
		emit_sentence(SM_OK);
		clear_fx();
		fx[FLD_ST0] = "45"; fx[FLD_ST1] = "2";
		emit_sentence(SM_OK);
		for (int m = SM_BADSUM; m <= SM_MANYCOMMA; m++) begin
			clear_fx();
			fx[FLD_ST0] = "2"; fx[FLD_ST1] = "3";
			emit_sentence(sent_mode_e'(m));
		end
		emit_padded(479);
		emit_padded(480);
		emit_padded(600);
		drain();

		write_reg(CFG_TZ, 40'd0);
		random_run(15);
		write_reg(CFG_TZ, 40'd23);
		write_reg(CFG_ID, 40'd0);
		random_run(15);
		write_reg(CFG_ID, 40'hFF_FFFF_FFFF);
		random_run(15);
		write_reg(CFG_TZ, 40'd5);
		write_reg(CFG_ID, 40'h47_4E_48_44_54);
		random_run(15);
		write_reg(CFG_ID, ID_RESET);
		random_run(15);

		repeat (10) @(posedge clk);
		if (fails == 0 && report_q.size() == 0)
			$display("tb_gnss_sentence_parser_unit: done, clean");
		else
			$display("tb_gnss_sentence_parser_unit: done, errors");
		$finish;
	end

	initial begin
		#6000000;
		$display("tb_gnss_sentence_parser_unit: done, errors");
		$finish;
	end

endmodule
